FILE: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, constants and helpers for the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES  = 32768;
  localparam int WORD_BITS  = 32;
  localparam int MAP_DEPTH  = MAX_PAGES / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int PAGE_W     = 15;
  localparam int COUNT_W    = 16;
  localparam int POP_W      = BIT_W + 1;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_RESERVE = 2'd2;
  localparam logic [1:0] ACT_INIT    = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [PAGE_W-1:0]  page_index;
    logic [COUNT_W-1:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [PAGE_W-1:0]  result_page;
    logic [COUNT_W-1:0] free_pages;
  } out_item_t;

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [POP_W-1:0] c;
    c = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      c = c + POP_W'(w[k]);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// used/free bitmap of physical pages with first-fit run allocation
// ----------------------------------------------------------------------------
// one transaction at a time; the map ram port moves one 32-page word per cycle
// allocate: scans words until a free run fits, then marks the words of the run
// free / reserve: reads and writes back the words touched by the range
// init: a sweep that clears all 1024 words of the map ram, then the result
// reset: the same sweep runs first; in_ready stays low meanwhile
// ----------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_MARK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int RUN_W = COUNT_W + 1;
  localparam int ISS_W = ADDR_W + 1;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [ISS_W-1:0]   issue_r, issue_nxt;   // next word to read or clear
  logic               pend_r, pend_nxt;     // read data arrives this cycle
  logic [ADDR_W-1:0]  wd_r, wd_nxt;         // word address of arriving data
  logic               init_r, init_nxt;     // sweep came from an init request
  logic [COUNT_W-1:0] total_r, total_nxt;   // page_total register
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;       // free page count
  logic               out_valid_r, out_valid_nxt;

  // per-transaction payload
  logic [RUN_W-1:0]   carry_r, carry_nxt;   // free run ending at previous word
  logic [COUNT_W-1:0] len_r, len_nxt;
  logic [PAGE_W-1:0]  lo_r, lo_nxt;         // first page of range
  logic [PAGE_W-1:0]  hl_r, hl_nxt;         // last page of range
  logic               mark_r, mark_nxt;
  logic               ok_r, ok_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  out_item_t          out_r, out_nxt;

  // map ram
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective total, clipped to the map size
  logic [COUNT_W-1:0] total_eff;
  logic [ISS_W-1:0]   scan_words;
  logic [COUNT_W:0]   total_sum;

  assign total_eff  = (total_r > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : total_r;
  assign total_sum  = {1'b0, total_eff} + (COUNT_W+1)'(WORD_BITS - 1);
  assign scan_words = total_sum[BIT_W +: ISS_W];

  // first-fit evaluation of the arriving word
  logic [WORD_BITS-1:0] used_w;
  logic [RUN_W-1:0]     run_a [WORD_BITS];
  logic                 hit;
  logic [BIT_W-1:0]     hit_j;
  logic [COUNT_W-1:0]   hit_page;
  logic [COUNT_W-1:0]   hit_first;

  always_comb begin
    logic             found;
    logic [BIT_W-1:0] h;
    for (int j = 0; j < WORD_BITS; j++) begin
      // pages beyond the total look used so no run reaches past it
      used_w[j] = ram_rdata[j] |
                  ({1'b0, wd_r, BIT_W'(j)} >= total_eff);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      found = 1'b0;
      h     = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (k <= j && used_w[k]) begin
          found = 1'b1;
          h     = BIT_W'(k);
        end
      end
      if (found) begin
        run_a[j] = RUN_W'(BIT_W'(j) - h);
      end else begin
        run_a[j] = carry_r + RUN_W'(j + 1);
      end
    end
    hit   = 1'b0;
    hit_j = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (run_a[j] == {1'b0, len_r}) begin
        hit   = 1'b1;
        hit_j = BIT_W'(j);
      end
    end
  end

  assign hit_page  = {1'b0, wd_r, hit_j};
  assign hit_first = hit_page + COUNT_W'(1) - len_r;

  // range marking of the arriving word
  logic [WORD_BITS-1:0] lo_mask, hi_mask, rng_mask, chg_mask, new_word;
  logic [POP_W-1:0]     chg_cnt;
  logic [COUNT_W:0]     cnt_up;

  assign lo_mask  = (wd_r == lo_r[PAGE_W-1:BIT_W]) ? ('1 << lo_r[BIT_W-1:0]) : '1;
  assign hi_mask  = (wd_r == hl_r[PAGE_W-1:BIT_W])
                  ? ('1 >> (BIT_W'(WORD_BITS - 1) - hl_r[BIT_W-1:0])) : '1;
  assign rng_mask = lo_mask & hi_mask;
  assign chg_mask = mark_r ? (rng_mask & ~ram_rdata) : (rng_mask & ram_rdata);
  assign new_word = mark_r ? (ram_rdata | rng_mask) : (ram_rdata & ~rng_mask);
  assign chg_cnt  = popcount(chg_mask);
  assign cnt_up   = {1'b0, cnt_r} + (COUNT_W+1)'(chg_cnt);

  // free / reserve range setup from the incoming transaction
  logic [COUNT_W:0]   rq_end, rq_hi;
  assign rq_end = {2'b0, in_data.page_index} + {1'b0, in_data.run_length};
  assign rq_hi  = (rq_end > {1'b0, total_eff}) ? {1'b0, total_eff} : rq_end;

  logic in_acc;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    wd_nxt        = wd_r;
    init_nxt      = init_r;
    total_nxt     = cfg_we ? cfg_wdata : total_r;
    cnt_nxt       = cnt_r;
    carry_nxt     = carry_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hl_nxt        = hl_r;
    mark_nxt      = mark_r;
    ok_nxt        = ok_r;
    page_nxt      = page_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = wd_r;
    ram_wdata     = new_word;
    ram_raddr     = issue_r[ADDR_W-1:0];

    case (state_r)
      ST_CLR: begin
        // sweep: word 0 keeps page 0 used
        ram_we    = 1'b1;
        ram_waddr = issue_r[ADDR_W-1:0];
        ram_wdata = (issue_r == '0) ? WORD_BITS'(1) : '0;
        issue_nxt = issue_r + ISS_W'(1);
        if (issue_r == ISS_W'(MAP_DEPTH - 1)) begin
          state_nxt = init_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          ok_nxt   = 1'b1;
          page_nxt = '0;
          len_nxt  = in_data.run_length;
          case (in_data.action)
            ACT_ALLOC: begin
              if (in_data.run_length != '0 && cnt_r >= in_data.run_length &&
                  in_data.run_length <= total_eff) begin
                state_nxt = ST_SCAN;
                issue_nxt = '0;
                carry_nxt = '0;
              end else begin
                ok_nxt    = 1'b0;
                state_nxt = ST_DONE;
              end
            end
            ACT_FREE, ACT_RESERVE: begin
              mark_nxt = (in_data.action == ACT_RESERVE);
              lo_nxt   = in_data.page_index;
              hl_nxt   = PAGE_W'(rq_hi - (COUNT_W+1)'(1));
              if ({2'b0, in_data.page_index} >= rq_hi) begin
                state_nxt = ST_DONE;
              end else begin
                issue_nxt = ISS_W'(in_data.page_index[PAGE_W-1:BIT_W]);
                state_nxt = ST_MARK;
              end
            end
            ACT_INIT: begin
              init_nxt  = 1'b1;
              issue_nxt = '0;
              cnt_nxt   = (total_eff != '0) ? total_eff - COUNT_W'(1) : '0;
              state_nxt = ST_CLR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // reads stream one word a cycle; each word is checked in the cycle after its read
        if (issue_r < scan_words) begin
          issue_nxt = issue_r + ISS_W'(1);
          pend_nxt  = 1'b1;
          wd_nxt    = issue_r[ADDR_W-1:0];
        end
        if (pend_r) begin
          if (hit) begin
            lo_nxt    = hit_first[PAGE_W-1:0];
            hl_nxt    = hit_page[PAGE_W-1:0];
            page_nxt  = hit_first[PAGE_W-1:0];
            mark_nxt  = 1'b1;
            issue_nxt = ISS_W'(hit_first[PAGE_W-1:BIT_W]);
            pend_nxt  = 1'b0;
            state_nxt = ST_MARK;
          end else begin
            carry_nxt = run_a[WORD_BITS-1];
          end
        end else if (issue_r >= scan_words) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_MARK: begin
        // read word n while writing back word n-1
        if (issue_r <= ISS_W'(hl_r[PAGE_W-1:BIT_W])) begin
          issue_nxt = issue_r + ISS_W'(1);
          pend_nxt  = 1'b1;
          wd_nxt    = issue_r[ADDR_W-1:0];
        end
        if (pend_r) begin
          ram_we = 1'b1;
          if (mark_r) begin
            cnt_nxt = (cnt_r > COUNT_W'(chg_cnt)) ? cnt_r - COUNT_W'(chg_cnt) : '0;
          end else begin
            cnt_nxt = cnt_up[COUNT_W] ? '1 : cnt_up[COUNT_W-1:0];
          end
        end else if (issue_r > ISS_W'(hl_r[PAGE_W-1:BIT_W])) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_nxt.ok          = ok_r;
          out_nxt.result_page = page_r;
          out_nxt.free_pages  = cnt_r;
          init_nxt          = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      issue_r     <= '0;
      pend_r      <= 1'b0;
      init_r      <= 1'b0;
      total_r     <= COUNT_W'(MAX_PAGES);
      cnt_r       <= COUNT_W'(MAX_PAGES - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      init_r      <= init_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wd_r    <= wd_nxt;
    carry_r <= carry_nxt;
    len_r   <= len_nxt;
    lo_r    <= lo_nxt;
    hl_r    <= hl_nxt;
    mark_r  <= mark_nxt;
    ok_r    <= ok_nxt;
    page_r  <= page_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // map is never written while waiting for a transaction
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("map write while idle");

  // a failed allocation reports page 0
  a_fail_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.result_page == '0))
    else $error("failed allocation with nonzero page");

  // only one transaction in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("accepted a second transaction");

  // range writes stay inside the range words
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK && ram_we) |->
      (wd_r >= lo_r[PAGE_W-1:BIT_W] && wd_r <= hl_r[PAGE_W-1:BIT_W]))
    else $error("map write outside range");

endmodule

FILE: bench/page_map_checker.sv
// ----------------------------------------------------------------------------
// page_map_checker
// watches the request and result channels of the page allocator, keeps its
// own copy of the used map and free count, and compares every result
// ----------------------------------------------------------------------------
module page_map_checker
  import bpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit              used_pages [MAX_PAGES];
  int unsigned     pages_left;
  int unsigned     page_limit;
  out_item_t       expected_results[$];

  function automatic int unsigned managed_total();
    return (page_limit < MAX_PAGES) ? page_limit : MAX_PAGES;
  endfunction

  function automatic void clear_map();
    int unsigned t;
    t = managed_total();
    foreach (used_pages[p]) used_pages[p] = 1'b0;
    used_pages[0] = 1'b1;
    pages_left = (t > 0) ? t - 1 : 0;
  endfunction

  function automatic out_item_t apply_request(in_item_t req);
    out_item_t   res;
    int unsigned t, run, len, p;
    bit          mark;
    t   = managed_total();
    len = req.run_length;
    res = '0;
    res.ok = 1'b1;
    case (req.action)
      ACT_ALLOC: begin
        res.ok = 1'b0;
        run = 0;
        if (len != 0 && pages_left >= len && len <= t) begin
          for (int unsigned i = 0; i < t; i++) begin
            run = used_pages[i] ? 0 : run + 1;
            if (run == len) begin
              for (int unsigned k = i + 1 - len; k <= i; k++) begin
                used_pages[k] = 1'b1;
                if (pages_left > 0) pages_left--;
              end
              res.result_page = PAGE_W'(i + 1 - len);
              res.ok = 1'b1;
              break;
            end
          end
        end
      end
      ACT_FREE, ACT_RESERVE: begin
        mark = (req.action == ACT_RESERVE);
        for (int unsigned i = 0; i < len; i++) begin
          p = req.page_index + i;
          if (p >= t) break;
          if (used_pages[p] != mark) begin
            used_pages[p] = mark;
            if (mark) begin
              if (pages_left > 0) pages_left--;
            end else if (pages_left < 65535) begin
              pages_left++;
            end
          end
        end
      end
      default: clear_map();
    endcase
    res.free_pages = COUNT_W'(pages_left);
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      page_limit = 32768;
      clear_map();
      expected_results.delete();
      fail_count = 0;
    end else begin
      // a request and a config write never coincide, testbench keeps them apart
      if (cfg_we) page_limit = cfg_wdata;
      if (in_valid && in_ready) expected_results.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.ok !== want.ok || out_data.result_page !== want.result_page ||
              out_data.free_pages !== want.free_pages) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
    end
  end
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// page allocator stimulus: directed corner requests, then random mixes of
// allocate, free, reserve and init under several page totals and idle patterns
// ----------------------------------------------------------------------------
module testbench;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 quiet_cycles;

  bitmap_page_allocator dut (.*);

  page_map_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall while the phase asks for it
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: any cycle without a transaction counts toward the limit
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one transaction on the request channel, with an optional idle gap first;
  // valid stays up after acceptance until the next idle gap or drain
  task automatic send_request(input logic [1:0] act, input int unsigned page,
                              input int unsigned len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, page_index: PAGE_W'(page), run_length: COUNT_W'(len)};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // register write only with nothing in flight
  task automatic write_total(input int unsigned value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly small runs near the low pages so allocations hit and free/reserve overlap
  task automatic random_request(input int unsigned span);
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(40);
    if (r < 45) send_request(ACT_ALLOC, $urandom_range(32767), len);
    else if (r < 72) send_request(ACT_FREE, $urandom_range(span), len);
    else if (r < 97) send_request(ACT_RESERVE, $urandom_range(span), len);
    else send_request(ACT_INIT, $urandom_range(32767), $urandom_range(65535));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners at the reset total
    send_request(ACT_ALLOC, 0, 0);          // zero-length run fails
    send_request(ACT_ALLOC, 0, 1);
    send_request(ACT_ALLOC, 32767, 5);
    send_request(ACT_RESERVE, 100, 50);
    send_request(ACT_ALLOC, 0, 200);        // skips the reserved hole
    send_request(ACT_FREE, 0, 1);           // page 0 may be freed
    send_request(ACT_ALLOC, 0, 1);
    send_request(ACT_ALLOC, 0, 32768);      // more than the free count
    send_request(ACT_ALLOC, 0, 65535);      // longer than the total
    send_request(ACT_FREE, 32767, 65535);   // last page, range runs off the end
    send_request(ACT_RESERVE, 32760, 100);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_RESERVE, 0, 0);
    send_request(ACT_FREE, 0, 32768);
    send_request(ACT_ALLOC, 0, 32768);      // whole map
    send_request(ACT_INIT, 32767, 65535);
    send_request(ACT_ALLOC, 0, 32767);
    send_request(ACT_INIT, 0, 0);

    // sender holds off until every result is back
    drain();

    // small total without init: pages beyond it are skipped, counter can run high
    write_total(40);
    send_request(ACT_FREE, 0, 100);
    send_request(ACT_ALLOC, 0, 41);
    send_request(ACT_ALLOC, 0, 40);
    send_request(ACT_INIT, 0, 0);
    send_request(ACT_ALLOC, 30, 39);
    send_request(ACT_RESERVE, 0, 65535);    // count saturates at zero
    write_total(0);
    send_request(ACT_INIT, 0, 0);
    send_request(ACT_ALLOC, 0, 1);
    send_request(ACT_FREE, 0, 10);
    write_total(65535);                     // clipped to the store size
    send_request(ACT_FREE, 0, 32768);       // counter far below the pages actually free
    send_request(ACT_INIT, 0, 0);

    // random phases with different totals and idle mixes
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned tot;
      int unsigned span;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      tot  = (ph == 3) ? 1 : (ph == 5) ? 32768 : $urandom_range(200, 8);
      span = (tot > 300) ? 300 : tot + 5;
      write_total(tot);
      if ($urandom_range(1)) send_request(ACT_INIT, 0, 0);
      for (int n = 0; n < 70; n++) random_request(span);
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bitmap_page_allocator.sv
bench/page_map_checker.sv
bench/testbench.sv
